>>> design/pdc_pkg.sv
`timescale 1ns / 1ps
// Package for the polymorphic dispatch cache: command and site-state codes and field widths.
// Depends on nothing; used by the interfaces and the top level.
package pdc_pkg;

	localparam int CMD_BITS   = 2;
	localparam int KEY_BITS   = 32;
	localparam int ADDR_BITS  = 32;
	localparam int HIT_BITS   = 32;
	localparam int STATE_BITS = 2;
	localparam int COUNT_BITS = 4;

	localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_INVAL  = 2'd2;

	localparam logic [STATE_BITS-1:0] SITE_UNINIT = 2'd0;
	localparam logic [STATE_BITS-1:0] SITE_MONO   = 2'd1;
	localparam logic [STATE_BITS-1:0] SITE_POLY   = 2'd2;
	localparam logic [STATE_BITS-1:0] SITE_MEGA   = 2'd3;

	localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

	typedef logic [CMD_BITS-1:0]   cmd_t;
	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [HIT_BITS-1:0]   hits_t;
	typedef logic [STATE_BITS-1:0] site_t;
	typedef logic [COUNT_BITS-1:0] count_t;

endpackage

>>> design/pdc_req_if.sv
`timescale 1ns / 1ps
// Request channel of the dispatch cache: valid, ready and one command transaction.
// Depends on pdc_pkg.
interface pdc_req_if;
	import pdc_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	key_t  type_key;
	addr_t target_addr;

	modport source (output valid, output cmd, output type_key, output target_addr, input ready);
	modport sink (input valid, input cmd, input type_key, input target_addr, output ready);
endinterface

>>> design/pdc_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the dispatch cache: valid, ready and one result transaction.
// Depends on pdc_pkg.
interface pdc_rsp_if;
	import pdc_pkg::*;

	logic   valid;
	logic   ready;
	logic   hit;
	addr_t  found_target;
	hits_t  entry_hits;
	site_t  site_state;
	count_t entry_count;

	modport source (output valid, output hit, output found_target, output entry_hits,
		output site_state, output entry_count, input ready);
	modport sink (input valid, input hit, input found_target, input entry_hits,
		input site_state, input entry_count, output ready);
endinterface

>>> design/polymorphic_dispatch_cache_unit.sv
`timescale 1ns / 1ps
// Single call-site polymorphic inline cache; entries live in one pdc_ram.
// A lookup reads the entries newest first (at most MAX_TYPES), one RAM read a cycle,
// until one matches the key or none is left.
// The next transaction is accepted once the result sits in the output register.
// Reset clears the site to uninitialised with no entries; RAM contents are not cleared.
// Depends on pdc_pkg, pdc_req_if, pdc_rsp_if and pdc_ram.
module polymorphic_dispatch_cache_unit #(
	parameter int MAX_TYPES   = 8,
	parameter int TYPE_BITS   = 32,
	parameter int TARGET_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	pdc_req_if.sink   req,
	pdc_rsp_if.source rsp
);
	import pdc_pkg::*;

	localparam int KEY_W  = (TYPE_BITS < KEY_BITS) ? TYPE_BITS : KEY_BITS;
	localparam int TGT_W  = (TARGET_BITS < ADDR_BITS) ? TARGET_BITS : ADDR_BITS;
	localparam int WORD_W = KEY_W + TGT_W + HIT_BITS;
	localparam int IDX_W  = $clog2(MAX_TYPES);
	localparam int CNT_W  = $clog2(MAX_TYPES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MONO = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	site_t            morph_q, morph_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [KEY_W-1:0] key_q;
	logic [TGT_W-1:0] tgt_q;
	logic             res_hit_q, res_hit_d;
	addr_t            res_tgt_q, res_tgt_d;
	hits_t            res_hits_q, res_hits_d;
	logic             rsp_valid_q;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic             req_fire;
	logic [KEY_W-1:0] req_key;
	logic [TGT_W-1:0] req_tgt;
	logic [KEY_W-1:0] rd_key;
	logic [TGT_W-1:0] rd_tgt;
	hits_t            rd_hits, inc_hits;
	logic [IDX_W-1:0] last_idx, tail_idx;
	logic             load_out;

	pdc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_TYPES)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign req_key   = req.type_key[KEY_W-1:0];
	assign req_tgt   = req.target_addr[TGT_W-1:0];

	assign rd_key   = ram_rdata[WORD_W-1 -: KEY_W];
	assign rd_tgt   = ram_rdata[HIT_BITS +: TGT_W];
	assign rd_hits  = ram_rdata[HIT_BITS-1:0];
	assign inc_hits = (rd_hits == HIT_MAX) ? rd_hits : rd_hits + hits_t'(1);

	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign tail_idx = IDX_W'(count_q);
	assign load_out = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		morph_d    = morph_q;
		idx_d      = idx_q;
		res_hit_d  = res_hit_q;
		res_tgt_d  = res_tgt_q;
		res_hits_d = res_hits_q;
		ram_we     = 1'b0;
		ram_waddr  = tail_idx;
		ram_wdata  = {key_q, tgt_q, hits_t'(0)};
		ram_re     = 1'b0;
		ram_raddr  = last_idx;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					res_hit_d  = 1'b0;
					res_tgt_d  = '0;
					res_hits_d = '0;
					state_d    = S_OUT;
					case (req.cmd)
						CMD_LOOKUP: begin
							if (count_q != '0) begin
								ram_re  = 1'b1;
								idx_d   = last_idx;
								state_d = S_SCAN;
							end
						end
						CMD_UPDATE: begin
							case (morph_q)
								SITE_UNINIT: begin
									ram_we    = 1'b1;
									ram_waddr = '0;
									ram_wdata = {req_key, req_tgt, hits_t'(0)};
									count_d   = CNT_W'(1);
									morph_d   = SITE_MONO;
								end
								SITE_MONO: begin
									ram_re  = 1'b1;
									state_d = S_MONO;
								end
								SITE_POLY: begin
									if (count_q == CNT_W'(MAX_TYPES)) begin
										morph_d = SITE_MEGA;
									end else begin
										ram_we    = 1'b1;
										ram_wdata = {req_key, req_tgt, hits_t'(0)};
										count_d   = count_q + CNT_W'(1);
									end
								end
								default: begin
								end
							endcase
						end
						CMD_INVAL: begin
							count_d = '0;
							morph_d = SITE_UNINIT;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (rd_key == key_q) begin
					ram_we     = 1'b1;
					ram_waddr  = idx_q;
					ram_wdata  = {rd_key, rd_tgt, inc_hits};
					res_hit_d  = 1'b1;
					res_tgt_d  = addr_t'(rd_tgt);
					res_hits_d = inc_hits;
					state_d    = S_OUT;
				end else if (idx_q == '0) begin
					state_d = S_OUT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_q - IDX_W'(1);
					idx_d     = idx_q - IDX_W'(1);
				end
			end
			S_MONO: begin
				if (rd_key != key_q) begin
					ram_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
					morph_d = SITE_POLY;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			morph_q     <= SITE_UNINIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			morph_q <= morph_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		res_hit_q  <= res_hit_d;
		res_tgt_q  <= res_tgt_d;
		res_hits_q <= res_hits_d;
		if (req_fire) begin
			key_q <= req_key;
			tgt_q <= req_tgt;
		end
		if (load_out) begin
			rsp.hit          <= res_hit_q;
			rsp.found_target <= res_tgt_q;
			rsp.entry_hits   <= res_hits_q;
			rsp.site_state   <= morph_q;
			rsp.entry_count  <= count_t'(count_q);
		end
	end

	assign rsp.valid = rsp_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TYPES))
		else $error("Entry count exceeds the number of ways.");

	a_uninit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		morph_q == SITE_UNINIT |-> count_q == '0)
		else $error("Uninitialised site holds entries.");

	a_mono_single: assert property (@(posedge clk) disable iff (!arst_n)
		morph_q == SITE_MONO |-> count_q == CNT_W'(1))
		else $error("Monomorphic site does not hold exactly one entry.");

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> rsp.entry_hits != '0)
		else $error("Lookup hit reported with a zero hit count.");

endmodule

>>> design/pdc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module pdc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
